// ----- hw/rtl/slt_pkg.sv -----
// Shared types, character codes, token kinds and the keyword table of the scanner.
package slt_pkg;

    localparam int KW_TABLE = 16;

    // Token kinds
    localparam logic [5:0] TK_DOT    = 6'd5;
    localparam logic [5:0] TK_BANG   = 6'd10;
    localparam logic [5:0] TK_EQ     = 6'd12;
    localparam logic [5:0] TK_LT     = 6'd14;
    localparam logic [5:0] TK_GT     = 6'd16;
    localparam logic [5:0] TK_SLASH  = 6'd18;
    localparam logic [5:0] TK_STRING = 6'd19;
    localparam logic [5:0] TK_NUMBER = 6'd20;
    localparam logic [5:0] TK_IDENT  = 6'd21;
    localparam logic [5:0] TK_KW0    = 6'd22;

    // Number kinds
    localparam logic [1:0] NK_INT   = 2'd0;
    localparam logic [1:0] NK_DEC   = 2'd1;
    localparam logic [1:0] NK_FLOAT = 2'd2;
    localparam logic [1:0] NK_OVF   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CHAR  = 2'd1;
    localparam logic [1:0] ERR_STR   = 2'd2;
    localparam logic [1:0] ERR_BLOCK = 2'd3;

    localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

    // Characters
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_F_UP   = 8'h46;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [7:0] PUNCT [10] = '{8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2C,
                                          8'h2E, 8'h2D, 8'h2B, 8'h3B, 8'h2A};

    localparam logic [47:0] KW_STR [KW_TABLE] = '{
        "var", "if", "else", "print", "func", "for", "while", "true",
        "false", "nil", "return", "and", "class", "or", "super", "this"};
    localparam logic [2:0] KW_LEN [KW_TABLE] = '{3'd3, 3'd2, 3'd4, 3'd5, 3'd4, 3'd3,
        3'd5, 3'd4, 3'd5, 3'd3, 3'd6, 3'd3, 3'd5, 3'd2, 3'd5, 3'd4};

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [1:0]  number_kind;
        logic [31:0] start_offset;
        logic [31:0] token_length;
        logic [30:0] integer_value;
        logic [1:0]  error_code;
        logic [7:0]  bad_char;
    } t_res;

    // Character i of keyword k, zero past its end.
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
        logic [7:0] ch;
        ch = 8'h00;
        if (i < KW_LEN[k])
            ch = KW_STR[k][(int'(KW_LEN[k]) - 1 - int'(i)) * 8 +: 8];
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [5:0] op_base(input logic [7:0] c);
        logic [5:0] k;
        if (c == CH_BANG)    k = TK_BANG;
        else if (c == CH_EQ) k = TK_EQ;
        else if (c == CH_LT) k = TK_LT;
        else                 k = TK_GT;
        return k;
    endfunction

endpackage

// ----- hw/rtl/slt_if.sv -----
// Valid/ready channel interfaces for source characters and result tokens.
interface slt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_source;
    modport source (output valid, char_code, end_of_source, input ready);
    modport sink   (input valid, char_code, end_of_source, output ready);
endinterface

interface slt_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [1:0]  number_kind;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [31:0] line_number;
    logic [30:0] integer_value;
    logic [1:0]  error_code;
    logic [7:0]  bad_char;
    logic        last_result;
    modport source (output valid, token_kind, number_kind, start_offset, token_length,
                    line_number, integer_value, error_code, bad_char, last_result,
                    input ready);
    modport sink   (input valid, token_kind, number_kind, start_offset, token_length,
                    line_number, integer_value, error_code, bad_char, last_result,
                    output ready);
endinterface

// ----- hw/rtl/slt_scan.sv -----
// Scanner state registers and the single-step next-state and result logic.
module slt_scan
    import slt_pkg::*;
#(
    parameter int OFFSET_BITS   = 32,
    parameter int KEYWORD_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_char,
    input  logic        i_eos,
    output t_res        o_res [3],
    output logic [1:0]  o_res_cnt,
    output logic [31:0] o_line
);
    localparam int KW_N = (KEYWORD_COUNT < KW_TABLE) ? KEYWORD_COUNT : KW_TABLE;
    localparam int OB   = OFFSET_BITS;

    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_SLASH = 4'd1;
    localparam logic [3:0] M_OP    = 4'd2;
    localparam logic [3:0] M_LCOM  = 4'd3;
    localparam logic [3:0] M_BLOCK = 4'd4;
    localparam logic [3:0] M_BSTAR = 4'd5;
    localparam logic [3:0] M_STR   = 4'd6;
    localparam logic [3:0] M_NUM   = 4'd7;
    localparam logic [3:0] M_NDOT  = 4'd8;
    localparam logic [3:0] M_IDENT = 4'd9;

    logic [3:0]      r_mode,  n_mode;
    logic [7:0]      r_held,  n_held;
    logic [OB-1:0]   r_pos,   n_pos;
    logic [OB-1:0]   r_ts,    n_ts;
    logic [31:0]     r_line,  n_line;
    logic [30:0]     r_acc,   n_acc;
    logic            r_ovf,   n_ovf;
    logic [KW_N-1:0] r_alive, n_alive;
    logic [2:0]      r_ilen,  n_ilen;
    logic            r_dec,   n_dec;

    t_res a_r0, a_r1, b_r;
    logic a_v0, a_v1, b_v, redo, line_up;

    function automatic logic [31:0] sat32(input logic [OB-1:0] d);
        logic [OB+31:0] e;
        e = {32'b0, d};
        return (|e[OB+31:32]) ? 32'hFFFF_FFFF : e[31:0];
    endfunction

    function automatic logic [31:0] low32(input logic [OB-1:0] d);
        logic [OB+31:0] e;
        e = {32'b0, d};
        return e[31:0];
    endfunction

    function automatic t_res mk(input logic [5:0] kind, input logic [1:0] nk,
                                input logic [OB-1:0] st, input logic [31:0] len,
                                input logic [30:0] val, input logic [1:0] err,
                                input logic [7:0] bad);
        t_res r;
        r.token_kind    = kind;
        r.number_kind   = nk;
        r.start_offset  = low32(st);
        r.token_length  = len;
        r.integer_value = val;
        r.error_code    = err;
        r.bad_char      = bad;
        return r;
    endfunction

    function automatic logic [31:0] digit_step(input logic [30:0] acc, input logic [7:0] c);
        logic [34:0] v;
        logic [7:0]  d;
        logic        o;
        d = c - CH_ZERO;
        v = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} + {27'b0, d};
        o = (v > {4'b0, INT_MAX31});
        return {o, o ? INT_MAX31 : v[30:0]};
    endfunction

    function automatic logic [KW_N-1:0] kw_step(input logic [KW_N-1:0] alive,
                                                 input logic [2:0] ilen,
                                                 input logic [7:0] c);
        logic [KW_N-1:0] m;
        m = alive;
        for (int k = 0; k < KW_N; k++)
            if (kw_char(k, ilen) != c) m[k] = 1'b0;
        return m;
    endfunction

    function automatic t_res num_res(input logic [OB-1:0] st, input logic [31:0] len,
                                     input logic dec, input logic ovf,
                                     input logic [30:0] acc);
        logic [1:0] nk;
        nk = dec ? NK_DEC : (ovf ? NK_OVF : NK_INT);
        return mk(TK_NUMBER, nk, st, len, (nk == NK_INT) ? acc : 31'd0, ERR_NONE, 8'd0);
    endfunction

    function automatic t_res ident_res(input logic [OB-1:0] st, input logic [31:0] len,
                                       input logic [KW_N-1:0] alive,
                                       input logic [2:0] ilen);
        logic [5:0] kind;
        kind = TK_IDENT;
        for (int k = 0; k < KW_N; k++)
            if (alive[k] && (KW_LEN[k] == ilen)) kind = TK_KW0 + 6'(k);
        return mk(kind, NK_INT, st, len, 31'd0, ERR_NONE, 8'd0);
    endfunction

    logic [OB-1:0] dot_pos;
    logic [31:0]   len_here, len_incl, len_dot;
    logic [31:0]   step;
    logic          punct_hit;
    logic [5:0]    punct_k;

    always_comb begin
        dot_pos  = r_pos - 1'b1;
        len_here = sat32(r_pos - r_ts);
        len_incl = sat32(r_pos + 1'b1 - r_ts);
        len_dot  = sat32(dot_pos - r_ts);
        step     = digit_step(r_acc, i_char);
        punct_hit = 1'b0;
        punct_k   = 6'd0;
        for (int k = 0; k < 10; k++)
            if (PUNCT[k] == i_char) begin
                punct_hit = 1'b1;
                punct_k   = 6'(k);
            end
    end

    always_comb begin
        n_mode  = r_mode;  n_held = r_held;  n_pos = r_pos + 1'b1;
        n_ts    = r_ts;    n_acc  = r_acc;   n_ovf = r_ovf;
        n_alive = r_alive; n_ilen = r_ilen;  n_dec = r_dec;
        a_v0 = 1'b0; a_v1 = 1'b0; b_v = 1'b0; redo = 1'b0; line_up = 1'b0;
        a_r0 = '0; a_r1 = '0; b_r = '0;
        if (i_eos) begin
            // flush the pending token (a number and its dot after a trailing dot), then back to reset values
            unique case (r_mode)
                M_SLASH: begin
                    a_v0 = 1'b1;
                    a_r0 = mk(TK_SLASH, NK_INT, r_ts, 32'd1, 31'd0, ERR_NONE, 8'd0);
                end
                M_OP: begin
                    a_v0 = 1'b1;
                    a_r0 = mk(op_base(r_held), NK_INT, r_ts, 32'd1, 31'd0, ERR_NONE, 8'd0);
                end
                M_BLOCK, M_BSTAR: begin
                    a_v0 = 1'b1;
                    a_r0 = mk(6'd0, NK_INT, r_ts, len_here, 31'd0, ERR_BLOCK, 8'd0);
                end
                M_STR: begin
                    a_v0 = 1'b1;
                    a_r0 = mk(6'd0, NK_INT, r_ts, len_here, 31'd0, ERR_STR, 8'd0);
                end
                M_NUM: begin
                    a_v0 = 1'b1;
                    a_r0 = num_res(r_ts, len_here, r_dec, r_ovf, r_acc);
                end
                M_NDOT: begin
                    a_v0 = 1'b1;
                    a_v1 = 1'b1;
                    a_r0 = num_res(r_ts, len_dot, r_dec, r_ovf, r_acc);
                    a_r1 = mk(TK_DOT, NK_INT, dot_pos, 32'd1, 31'd0, ERR_NONE, 8'd0);
                end
                M_IDENT: begin
                    a_v0 = 1'b1;
                    a_r0 = ident_res(r_ts, len_here, r_alive, r_ilen);
                end
                default: ;
            endcase
            n_mode = M_IDLE; n_held = 8'd0; n_pos = '0; n_ts = '0;
            n_acc = '0; n_ovf = 1'b0; n_alive = '1; n_ilen = '0; n_dec = 1'b0;
        end else begin
            unique case (r_mode)
                M_SLASH: begin
                    if (i_char == CH_SLASH) n_mode = M_LCOM;
                    else if (i_char == CH_STAR) n_mode = M_BLOCK;
                    else begin
                        a_v0 = 1'b1;
                        a_r0 = mk(TK_SLASH, NK_INT, r_ts, 32'd1, 31'd0, ERR_NONE, 8'd0);
                        redo = 1'b1;
                    end
                end
                M_OP: begin
                    a_v0 = 1'b1;
                    if (i_char == CH_EQ) begin
                        a_r0 = mk(op_base(r_held) + 6'd1, NK_INT, r_ts, 32'd2, 31'd0,
                                  ERR_NONE, 8'd0);
                        n_mode = M_IDLE;
                    end else begin
                        a_r0 = mk(op_base(r_held), NK_INT, r_ts, 32'd1, 31'd0,
                                  ERR_NONE, 8'd0);
                        redo = 1'b1;
                    end
                end
                M_LCOM: begin
                    if (i_char == CH_NL) begin
                        line_up = 1'b1;
                        n_mode  = M_IDLE;
                    end
                end
                M_BLOCK, M_BSTAR: begin
                    if (r_mode == M_BSTAR && i_char == CH_SLASH) n_mode = M_IDLE;
                    else if (i_char == CH_STAR) n_mode = M_BSTAR;
                    else begin
                        line_up = (i_char == CH_NL);
                        n_mode  = M_BLOCK;
                    end
                end
                M_STR: begin
                    if (i_char == CH_QUOTE) begin
                        a_v0 = 1'b1;
                        a_r0 = mk(TK_STRING, NK_INT, r_ts, len_incl, 31'd0, ERR_NONE, 8'd0);
                        n_mode = M_IDLE;
                    end else begin
                        line_up = (i_char == CH_NL);
                    end
                end
                M_NUM, M_NDOT: begin
                    if (is_digit(i_char)) begin
                        if (r_mode == M_NDOT) begin
                            n_dec  = 1'b1;
                            n_mode = M_NUM;
                        end else if (!r_dec) begin
                            n_ovf = r_ovf | step[31];
                            n_acc = step[30:0];
                        end
                    end else if (i_char == CH_F_LO || i_char == CH_F_UP) begin
                        a_v0 = 1'b1;
                        a_r0 = mk(TK_NUMBER, NK_FLOAT, r_ts, len_incl, 31'd0, ERR_NONE, 8'd0);
                        n_mode = M_IDLE;
                    end else if (r_mode == M_NUM && i_char == CH_DOT && !r_dec) begin
                        n_mode = M_NDOT;
                    end else if (r_mode == M_NUM) begin
                        a_v0 = 1'b1;
                        a_r0 = num_res(r_ts, len_here, r_dec, r_ovf, r_acc);
                        redo = 1'b1;
                    end else begin
                        a_v0 = 1'b1;
                        a_v1 = 1'b1;
                        a_r0 = num_res(r_ts, len_dot, r_dec, r_ovf, r_acc);
                        a_r1 = mk(TK_DOT, NK_INT, dot_pos, 32'd1, 31'd0, ERR_NONE, 8'd0);
                        redo = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(i_char) || is_digit(i_char) || i_char == CH_UNDER) begin
                        n_alive = kw_step(r_alive, r_ilen, i_char);
                        n_ilen  = (r_ilen == 3'd7) ? r_ilen : r_ilen + 3'd1;
                    end else begin
                        a_v0 = 1'b1;
                        a_r0 = ident_res(r_ts, len_here, r_alive, r_ilen);
                        redo = 1'b1;
                    end
                end
                default: redo = 1'b1;
            endcase

            // second pass: the character seen from between tokens
            if (redo) begin
                n_mode = M_IDLE;
                if (is_space(i_char)) begin
                    line_up = (i_char == CH_NL);
                end else begin
                    n_ts = r_pos;
                    if (punct_hit) begin
                        b_v = 1'b1;
                        b_r = mk(punct_k, NK_INT, r_pos, 32'd1, 31'd0, ERR_NONE, 8'd0);
                    end else if (i_char == CH_BANG || i_char == CH_EQ ||
                                 i_char == CH_LT || i_char == CH_GT) begin
                        n_mode = M_OP;
                        n_held = i_char;
                    end else if (i_char == CH_SLASH) begin
                        n_mode = M_SLASH;
                    end else if (i_char == CH_QUOTE) begin
                        n_mode = M_STR;
                    end else if (is_digit(i_char)) begin
                        n_mode = M_NUM;
                        n_acc  = {23'd0, i_char - CH_ZERO};
                        n_ovf  = 1'b0;
                        n_dec  = 1'b0;
                    end else if (is_alpha(i_char) || i_char == CH_UNDER) begin
                        n_mode  = M_IDENT;
                        n_alive = kw_step('1, 3'd0, i_char);
                        n_ilen  = 3'd1;
                    end else begin
                        b_v = 1'b1;
                        b_r = mk(6'd0, NK_INT, r_pos, 32'd1, 31'd0, ERR_CHAR, i_char);
                    end
                end
            end
        end
        n_line = (i_eos) ? 32'd1 :
                 (line_up && r_line != 32'hFFFF_FFFF) ? r_line + 32'd1 : r_line;
    end

    // compact results in order of emission
    always_comb begin
        o_res[0]  = a_v0 ? a_r0 : b_r;
        o_res[1]  = a_v1 ? a_r1 : b_r;
        o_res[2]  = b_r;
        o_res_cnt = {1'b0, a_v0} + {1'b0, a_v1} + {1'b0, b_v};
        o_line    = r_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_held <= 8'd0; r_pos <= '0; r_ts <= '0;
            r_line <= 32'd1; r_acc <= '0; r_ovf <= 1'b0; r_alive <= '1;
            r_ilen <= '0; r_dec <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode; r_held <= n_held; r_pos <= n_pos; r_ts <= n_ts;
            r_line <= n_line; r_acc <= n_acc; r_ovf <= n_ovf; r_alive <= n_alive;
            r_ilen <= n_ilen; r_dec <= n_dec;
        end
    end

endmodule

// ----- hw/rtl/source_lexer_tokenizer_top.sv -----
// Top level of the streaming lexical scanner: scan step plus result buffer.
// An item's first result is registered and valid in the cycle after the item is accepted.
// Throughput: one character item per cycle while the receiver is ready; an item
// causing two or three results holds the input while the three-entry result
// buffer drains, one result per cycle as the receiver accepts them.
// Reset (synchronous, i_rst_n low): scanner idle, offset 0, line 1, buffer empty.
module source_lexer_tokenizer_top
    import slt_pkg::*;
#(
    parameter int OFFSET_BITS   = 32,
    parameter int KEYWORD_COUNT = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    slt_in_if.sink    i_src,
    slt_out_if.source o_tok
);
    t_res        s_res [3];
    logic [1:0]  s_cnt;
    logic [31:0] s_line;
    logic        take;
    logic        out_take;

    // result buffer: one batch of up to three results per accepted item
    t_res        r_slot [3];
    logic [1:0]  r_head;
    logic [1:0]  r_cnt;
    logic [31:0] r_line;

    slt_scan #(
        .OFFSET_BITS   (OFFSET_BITS),
        .KEYWORD_COUNT (KEYWORD_COUNT)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_char    (i_src.char_code),
        .i_eos     (i_src.end_of_source),
        .o_res     (s_res),
        .o_res_cnt (s_cnt),
        .o_line    (s_line)
    );

    // Take a new item when the buffer is empty or its last result leaves now.
    assign i_src.ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_tok.ready);
    assign take        = i_src.valid && i_src.ready;
    assign out_take    = o_tok.valid && o_tok.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 2'd0;
        end else if (take) begin
            r_cnt  <= s_cnt;
            r_head <= 2'd0;
        end else if (out_take) begin
            r_cnt  <= r_cnt - 2'd1;
            r_head <= r_head + 2'd1;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_slot <= s_res;
            r_line <= s_line;    // every result of an item carries the line before it
        end
    end

    assign o_tok.valid         = (r_cnt != 2'd0);
    assign o_tok.token_kind    = r_slot[r_head].token_kind;
    assign o_tok.number_kind   = r_slot[r_head].number_kind;
    assign o_tok.start_offset  = r_slot[r_head].start_offset;
    assign o_tok.token_length  = r_slot[r_head].token_length;
    assign o_tok.integer_value = r_slot[r_head].integer_value;
    assign o_tok.error_code    = r_slot[r_head].error_code;
    assign o_tok.bad_char      = r_slot[r_head].bad_char;
    assign o_tok.line_number   = r_line;
    assign o_tok.last_result   = (r_cnt == 2'd1);

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd0 |-> ({1'b0, r_head} + {1'b0, r_cnt}) <= 3'd3)
        else $error("result buffer head/count out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (r_cnt == 2'd0) || out_take)
        else $error("new batch would overwrite undelivered results");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !take) |=> r_cnt == $past(r_cnt) - 2'd1)
        else $error("buffer count did not drop after delivery");

endmodule

// ----- tb/tb_checker.sv -----
// Scanner checker: predicts result tokens from accepted characters and compares them.
`timescale 1ns / 100ps
module tb_checker
    import slt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    slt_in_if    src,
    slt_out_if   tok,
    output int   o_fail_count,
    output int   o_pending
);

    typedef enum logic [3:0] {
        SM_IDLE, SM_SLASH, SM_OP, SM_LCOM, SM_BLOCK, SM_BSTAR, SM_STR, SM_NUM, SM_NDOT,
        SM_IDENT
    } scan_mode_e;

    typedef struct {
        logic [5:0]  kind;
        logic [1:0]  nkind;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
        logic [30:0] value;
        logic [1:0]  err;
        logic [7:0]  bad;
        logic        last;
    } token_t;

    scan_mode_e  mode;
    logic [7:0]  held;
    logic [31:0] pos;
    logic [31:0] tok_start;
    logic [31:0] line_cnt;
    logic [30:0] acc;
    logic        ovf;
    logic [15:0] kw_alive;
    logic [2:0]  id_len;
    logic        dec_seen;

    token_t step_toks[$];
    token_t token_q[$];
    int     fails;

    task automatic clear_scan();
        mode = SM_IDLE; held = '0; pos = '0; tok_start = '0; line_cnt = 32'd1;
        acc = '0; ovf = 1'b0; kw_alive = '1; id_len = '0; dec_seen = 1'b0;
    endtask

    task automatic add_tok(input logic [5:0] kind, input logic [1:0] nk,
                           input logic [31:0] st, input logic [31:0] len,
                           input logic [30:0] val, input logic [1:0] err,
                           input logic [7:0] bad);
        token_t t;
        t.kind = kind; t.nkind = nk; t.start = st; t.len = len; t.line = line_cnt;
        t.value = val; t.err = err; t.bad = bad; t.last = 1'b0;
        step_toks.push_back(t);
    endtask

    task automatic bump_line();
        if (line_cnt != 32'hFFFF_FFFF) line_cnt++;
    endtask

    task automatic add_number(input logic [31:0] stop);
        logic [1:0] nk;
        nk = dec_seen ? NK_DEC : (ovf ? NK_OVF : NK_INT);
        add_tok(TK_NUMBER, nk, tok_start, stop - tok_start, (nk == NK_INT) ? acc : '0,
                ERR_NONE, '0);
    endtask

    task automatic add_digit(input logic [7:0] c);
        logic [63:0] v;
        v = 64'(acc) * 10 + 64'(c - CH_ZERO);
        if (v > 64'(INT_MAX31)) begin
            v = 64'(INT_MAX31);
            ovf = 1'b1;
        end
        acc = v[30:0];
    endtask

    task automatic ident_char(input logic [7:0] c);
        logic [7:0] kc;
        for (int k = 0; k < KW_TABLE; k++) begin
            kc = 8'h00;
            if (id_len < KW_LEN[k]) kc = KW_STR[k][(int'(KW_LEN[k]) - 1 - int'(id_len)) * 8 +: 8];
            if (kc != c) kw_alive[k] = 1'b0;
        end
        if (id_len < 3'd7) id_len++;
    endtask

    task automatic add_ident();
        logic [5:0] kind;
        kind = TK_IDENT;
        for (int k = 0; k < KW_TABLE; k++)
            if (kw_alive[k] && KW_LEN[k] == id_len) kind = TK_KW0 + 6'(k);
        add_tok(kind, NK_INT, tok_start, pos - tok_start, '0, ERR_NONE, '0);
    endtask

    function automatic logic digit_c(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic alpha_c(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    task automatic idle_char(input logic [7:0] c);
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            if (c == CH_NL) bump_line();
            return;
        end
        tok_start = pos;
        for (int k = 0; k < 10; k++)
            if (PUNCT[k] == c) begin
                add_tok(6'(k), NK_INT, pos, 32'd1, '0, ERR_NONE, '0);
                return;
            end
        if (c == CH_BANG || c == CH_EQ || c == CH_LT || c == CH_GT) begin
            mode = SM_OP; held = c;
        end else if (c == CH_SLASH) begin
            mode = SM_SLASH;
        end else if (c == CH_QUOTE) begin
            mode = SM_STR;
        end else if (digit_c(c)) begin
            mode = SM_NUM; acc = '0; ovf = 1'b0; dec_seen = 1'b0;
            add_digit(c);
        end else if (alpha_c(c) || c == CH_UNDER) begin
            mode = SM_IDENT; kw_alive = '1; id_len = '0;
            ident_char(c);
        end else begin
            add_tok('0, NK_INT, pos, 32'd1, '0, ERR_CHAR, c);
        end
    endtask

    function automatic logic [5:0] op_kind(input logic [7:0] c);
        if (c == CH_BANG) return TK_BANG;
        if (c == CH_EQ) return TK_EQ;
        if (c == CH_LT) return TK_LT;
        return TK_GT;
    endfunction

    task automatic scan_char(input logic [7:0] c);
        logic again;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (mode)
                SM_SLASH: begin
                    if (c == CH_SLASH) mode = SM_LCOM;
                    else if (c == CH_STAR) mode = SM_BLOCK;
                    else begin
                        add_tok(TK_SLASH, NK_INT, tok_start, 32'd1, '0, ERR_NONE, '0);
                        mode = SM_IDLE; again = 1'b1;
                    end
                end
                SM_OP: begin
                    if (c == CH_EQ) begin
                        add_tok(op_kind(held) + 6'd1, NK_INT, tok_start, 32'd2, '0, ERR_NONE, '0);
                        mode = SM_IDLE;
                    end else begin
                        add_tok(op_kind(held), NK_INT, tok_start, 32'd1, '0, ERR_NONE, '0);
                        mode = SM_IDLE; again = 1'b1;
                    end
                end
                SM_LCOM: begin
                    if (c == CH_NL) begin
                        bump_line(); mode = SM_IDLE;
                    end
                end
                SM_BLOCK, SM_BSTAR: begin
                    if (mode == SM_BSTAR && c == CH_SLASH) mode = SM_IDLE;
                    else if (c == CH_STAR) mode = SM_BSTAR;
                    else begin
                        if (c == CH_NL) bump_line();
                        mode = SM_BLOCK;
                    end
                end
                SM_STR: begin
                    if (c == CH_QUOTE) begin
                        add_tok(TK_STRING, NK_INT, tok_start, pos + 1 - tok_start, '0,
                                ERR_NONE, '0);
                        mode = SM_IDLE;
                    end else if (c == CH_NL) bump_line();
                end
                SM_NUM: begin
                    if (digit_c(c)) begin
                        if (!dec_seen) add_digit(c);
                    end else if (c == CH_F_LO || c == CH_F_UP) begin
                        add_tok(TK_NUMBER, NK_FLOAT, tok_start, pos + 1 - tok_start, '0,
                                ERR_NONE, '0);
                        mode = SM_IDLE;
                    end else if (c == CH_DOT && !dec_seen) mode = SM_NDOT;
                    else begin
                        add_number(pos); mode = SM_IDLE; again = 1'b1;
                    end
                end
                SM_NDOT: begin
                    if (digit_c(c)) begin
                        dec_seen = 1'b1; mode = SM_NUM;
                    end else if (c == CH_F_LO || c == CH_F_UP) begin
                        add_tok(TK_NUMBER, NK_FLOAT, tok_start, pos + 1 - tok_start, '0,
                                ERR_NONE, '0);
                        mode = SM_IDLE;
                    end else begin
                        // number ends before the dot, dot becomes its own token
                        add_number(pos - 1);
                        add_tok(TK_DOT, NK_INT, pos - 1, 32'd1, '0, ERR_NONE, '0);
                        mode = SM_IDLE; again = 1'b1;
                    end
                end
                SM_IDENT: begin
                    if (alpha_c(c) || digit_c(c) || c == CH_UNDER) ident_char(c);
                    else begin
                        add_ident(); mode = SM_IDLE; again = 1'b1;
                    end
                end
                default: begin
                    mode = SM_IDLE;
                    idle_char(c);
                end
            endcase
        end
    endtask

    task automatic flush_source();
        case (mode)
            SM_SLASH: add_tok(TK_SLASH, NK_INT, tok_start, 32'd1, '0, ERR_NONE, '0);
            SM_OP:    add_tok(op_kind(held), NK_INT, tok_start, 32'd1, '0, ERR_NONE, '0);
            SM_BLOCK, SM_BSTAR:
                add_tok('0, NK_INT, tok_start, pos - tok_start, '0, ERR_BLOCK, '0);
            SM_STR:   add_tok('0, NK_INT, tok_start, pos - tok_start, '0, ERR_STR, '0);
            SM_NUM:   add_number(pos);
            SM_NDOT: begin
                add_number(pos - 1);
                add_tok(TK_DOT, NK_INT, pos - 1, 32'd1, '0, ERR_NONE, '0);
            end
            SM_IDENT: add_ident();
            default: ;
        endcase
        clear_scan();
    endtask

    task automatic check_token();
        token_t e;
        if (token_q.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("%0t: token with nothing expected: kind %0d err %0d start %0d",
                         $time, tok.token_kind, tok.error_code, tok.start_offset);
            return;
        end
        e = token_q.pop_front();
        if (tok.token_kind !== e.kind || tok.number_kind !== e.nkind ||
            tok.start_offset !== e.start || tok.token_length !== e.len ||
            tok.line_number !== e.line || tok.integer_value !== e.value ||
            tok.error_code !== e.err || tok.bad_char !== e.bad ||
            tok.last_result !== e.last) begin
            fails++;
            if (fails <= 10)
                $display({"%0t: token mismatch exp kind %0d nk %0d start %0d len %0d ",
                          "line %0d val %0d err %0d bad %0h last %0d / got %0d %0d %0d ",
                          "%0d %0d %0d %0d %0h %0d"}, $time,
                         e.kind, e.nkind, e.start, e.len, e.line, e.value, e.err, e.bad,
                         e.last, tok.token_kind, tok.number_kind, tok.start_offset,
                         tok.token_length, tok.line_number, tok.integer_value,
                         tok.error_code, tok.bad_char, tok.last_result);
        end
    endtask

    initial begin
        fails = 0;
        clear_scan();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            token_q.delete();
        end else begin
            if (src.valid && src.ready) begin
                step_toks.delete();
                if (src.end_of_source) flush_source();
                else begin
                    scan_char(src.char_code);
                    pos = pos + 1;
                end
                if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
                foreach (step_toks[i]) token_q.push_back(step_toks[i]);
            end
            if (tok.valid && tok.ready) check_token();
        end
        o_pending    <= token_q.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top: clock, reset, character stimulus, receiver stalls and the verdict.
`timescale 1ns / 100ps
module tb_top;
    import slt_pkg::*;

    logic clk;
    logic rst_n;

    slt_in_if  src_ch ();
    slt_out_if tok_ch ();

    int fail_count;
    int pending;

    // Idle percentages for the current phase and a long receiver hold-off.
    int src_idle_pct;
    int rcv_idle_pct;
    int hold_cycles;
    logic hold_req;

    source_lexer_tokenizer_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_src   (src_ch),
        .o_tok   (tok_ch)
    );

    tb_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .src          (src_ch),
        .tok          (tok_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: random stalls, or a counted hold-off once requested.
    initial begin
        tok_ch.ready = 1'b0;
        hold_cycles  = 0;
        forever begin
            @(negedge clk);
            if (hold_req && hold_cycles == 0) hold_cycles = 90;
            if (hold_cycles > 0) begin
                tok_ch.ready = 1'b0;
                hold_cycles--;
            end else begin
                tok_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one item; returns after the accepting edge, at the next falling edge.
    task automatic send(input logic [7:0] c, input logic eos);
        while ($urandom_range(99) < src_idle_pct) begin
            src_ch.valid = 1'b0;
            @(negedge clk);
        end
        src_ch.valid         = 1'b1;
        src_ch.char_code     = c;
        src_ch.end_of_source = eos;
        do @(posedge clk); while (!src_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
    endtask

    // Stop offering until every predicted token has come out.
    task automatic drain();
        src_ch.valid = 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [7:0] ident_byte();
        case ($urandom_range(3))
            0:       return 8'h61 + 8'($urandom_range(25));
            1:       return 8'h41 + 8'($urandom_range(25));
            2:       return CH_ZERO + 8'($urandom_range(9));
            default: return CH_UNDER;
        endcase
    endfunction

    // One lexical fragment: mostly well-formed tokens, some noise and broken ones.
    task automatic send_fragment(inout int n);
        string kw [16] = '{"var", "if", "else", "print", "func", "for", "while", "true",
                           "false", "nil", "return", "and", "class", "or", "super", "this"};
        string ops [9] = '{"!", "!=", "=", "==", "<", "<=", ">", ">=", "/"};
        string s;
        int    len;
        s = "";
        case ($urandom_range(11))
            0, 1: begin
                s = kw[$urandom_range(15)];
                // sometimes extend a keyword into a plain identifier
                if ($urandom_range(3) == 0) s = {s, string'(ident_byte())};
            end
            2: begin
                s = string'(8'h61 + 8'($urandom_range(25)));
                len = $urandom_range(9);
                for (int i = 0; i < len; i++) s = {s, string'(ident_byte())};
            end
            3: begin
                len = ($urandom_range(4) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 5);
                for (int i = 0; i < len; i++) s = {s, string'(CH_ZERO + 8'($urandom_range(9)))};
                case ($urandom_range(4))
                    0: s = {s, ".", string'(CH_ZERO + 8'($urandom_range(9))), "5"};
                    1: s = {s, ($urandom_range(1) != 0) ? "f" : "F"};
                    2: s = {s, ".", ($urandom_range(1) != 0) ? "x" : "f"};
                    default: ;
                endcase
            end
            4: s = ($urandom_range(2) == 0) ? "\"a\nb\"" : "\"str ing\"";
            5: s = "// note */\n";
            6: s = ($urandom_range(1) != 0) ? "/* a\n** b */" : "/*x*/";
            7: s = ops[$urandom_range(8)];
            8: s = string'(PUNCT[$urandom_range(9)]);
            9: s = ($urandom_range(1) != 0) ? "\n" : "\t ";
            10: begin
                send(8'($urandom_range(255)), 1'b0);
                n++;
            end
            default: begin
                // unterminated string, comment, number with a dot or operator, closed by the end marker
                case ($urandom_range(3))
                    0: send_text("\"open");
                    1: send_text("/* open *");
                    2: send_text("12.");
                    default: send_text("!");
                endcase
                send(8'($urandom_range(255)), 1'b1);
                n += 5;
            end
        endcase
        for (int i = 0; i < s.len(); i++) begin
            send(s[i], 1'b0);
            n++;
        end
        if ($urandom_range(2) != 0) begin
            send(($urandom_range(5) == 0) ? CH_NL : 8'h20, 1'b0);
            n++;
        end
    endtask

    task automatic random_phase(input int items);
        int n;
        n = 0;
        while (n < items) begin
            send_fragment(n);
            if ($urandom_range(40) == 0) begin
                send(8'h00, 1'b1);
                n++;
            end
        end
        send(8'hFF, 1'b1);
    endtask

    initial begin
        src_ch.valid         = 1'b0;
        src_ch.char_code     = '0;
        src_ch.end_of_source = 1'b0;
        hold_req             = 1'b0;
        src_idle_pct         = 32;
        rcv_idle_pct         = 58;
        rst_n                = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: operators, number then dot, float suffix, overflow, bad bytes,
        // an identifier and a keyword, string across a line, open block comment at the end.
        send_text("!=<>= 7.a 9.5f 99999999999 superx or");
        send(8'h00, 1'b0);
        send(8'hFF, 1'b0);
        send_text("\"s\n\"/*\n");
        send(8'h00, 1'b1);
        drain();

        random_phase(55);
        drain();

        src_idle_pct = 58;
        rcv_idle_pct = 32;
        random_phase(55);
        drain();

        src_idle_pct = 0;
        rcv_idle_pct = 0;
        // long receiver hold-off while characters keep coming; request it once
        hold_req = 1'b1;
        wait (hold_cycles != 0);
        hold_req = 1'b0;
        send_text("+-*;,(){}");
        random_phase(52);
        drain();

        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
